/* rtl/u8cu_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 to code units: shared package
// Field widths, register map, decoder constants and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package u8cu_pkg;

	// Payload widths.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEFT_W   = 3;
	localparam int unsigned UNIT_W   = 31;
	localparam int unsigned MODE_W   = 2;

	// Configuration port.
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;
	localparam logic [PADDR_W-3:0] REG_OUTPUT_MODE = 1'b0;

	// Output modes.
	localparam logic [MODE_W-1:0] MODE_UCS2  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UCS4  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UTF16 = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UTF32 = 2'd3;
	localparam logic [MODE_W-1:0] MODE_RESET = MODE_UTF32;

	// Decoder phases.
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_COLLECT = 2'd1;
	localparam logic [1:0] PH_STRAY   = 2'd2;
	localparam logic [1:0] PH_SWALLOW = 2'd3;

	// Code point constants.
	localparam logic [UNIT_W-1:0] CP_REPL      = 31'h0000_fffd;
	localparam logic [UNIT_W-1:0] CP_SUPP_BASE = 31'h0001_0000;
	localparam logic [UNIT_W-1:0] CP_LIMIT     = 31'h0011_0000;
	localparam logic [UNIT_W-1:0] CP_SUR_LO    = 31'h0000_d800;
	localparam logic [UNIT_W-1:0] CP_SUR_HI    = 31'h0000_dfff;
	localparam logic [UNIT_W-1:0] CP_NONCH_LO  = 31'h0000_fffe;
	localparam logic [UNIT_W-1:0] CP_NONCH_HI  = 31'h0000_ffff;
	localparam logic [15:0]       HI_SUR_BASE  = 16'hd800;
	localparam logic [15:0]       LO_SUR_BASE  = 16'hdc00;
	localparam logic [9:0]        SUR_MASK     = 10'h3ff;

	// Result queue.
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic              err;
		logic              last;
	} result_t;

	// Up to two units produced by one byte; the second never carries an error.
	typedef struct packed {
		logic [1:0]        cnt;
		logic [UNIT_W-1:0] u0;
		logic              e0;
		logic [UNIT_W-1:0] u1;
	} emit_t;

	typedef struct packed {
		emit_t             em;
		logic [1:0]        phase;
		logic [LEFT_W-1:0] expected;
		logic [LEFT_W-1:0] seen;
		logic [UNIT_W-1:0] partial;
	} dec_t;

	// Smallest code point that a sequence of the given length may encode.
	function automatic logic [UNIT_W-1:0] min_for_size(input logic [LEFT_W-1:0] size);
		logic [UNIT_W-1:0] m;
		unique case (size)
			3'd2:    m = 31'h0000_0080;
			3'd3:    m = 31'h0000_0800;
			3'd4:    m = 31'h0001_0000;
			3'd5:    m = 31'h0020_0000;
			3'd6:    m = 31'h0400_0000;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* rtl/u8cu_ifs.sv */
// ----------------------------------------------------------------------------
// UTF-8 to code units: stream interfaces
// Valid/ready channels for input bytes and for decoded code units.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8cu_in_if import u8cu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic [LEFT_W-1:0] bytes_left;

	modport source (output valid, output in_byte, output bytes_left, input ready);
	modport sink   (input valid, input in_byte, input bytes_left, output ready);
endinterface

interface u8cu_out_if import u8cu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [UNIT_W-1:0] code_unit;
	logic              range_error;
	logic              last_of_run;

	modport source (output valid, output code_unit, output range_error,
		output last_of_run, input ready);
	modport sink   (input valid, input code_unit, input range_error,
		input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/utf8_to_code_units_top.sv */
// ----------------------------------------------------------------------------
// UTF-8 to code units decoder
// Decodes a UTF-8 byte stream (forms up to six bytes) into UCS-2, UCS-4,
// UTF-16 or UTF-32 code units, replacing malformed input with U+FFFD.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the input register until the result queue
//   has two free entries, counting one the sink frees in that cycle, and is then
//   decoded into the queue; its units are offered in order behind earlier ones.
// Throughput: one byte per cycle while each byte yields at most one unit and
//   the sink takes a unit every cycle; the output moves one unit a cycle while ready is high.
// Reset (arst_n low): decoder idle, result queue empty, output_mode = UTF-32.
`default_nettype none

module utf8_to_code_units_top import u8cu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	u8cu_in_if.sink             in_stream,
	u8cu_out_if.source          out_stream,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	// ------------------------------------------------------------------
	// Configuration register. Writes complete in the APB access phase.
	// ------------------------------------------------------------------
	logic [MODE_W-1:0] mode_q;
	logic              cfg_wr;
	logic              sel_mode;

	assign pready   = 1'b1;
	assign sel_mode = (paddr[PADDR_W-1:2] == REG_OUTPUT_MODE);
	assign cfg_wr   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_wr && sel_mode) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	assign prdata = sel_mode ? {{(PDATA_W-MODE_W){1'b0}}, mode_q} : '0;

	// ------------------------------------------------------------------
	// Input register (stage 1). A byte sits here until the result queue
	// has room for the two units it may produce.
	// ------------------------------------------------------------------
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [LEFT_W-1:0] left_s1;
	logic              fire_s1;
	logic              in_acc;

	assign in_stream.ready = !valid_s1 || fire_s1;
	assign in_acc          = in_stream.valid && in_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_stream.ready) begin
			valid_s1 <= in_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_stream.in_byte;
			left_s1 <= in_stream.bytes_left;
		end
	end

	// ------------------------------------------------------------------
	// Decoder state.
	// ------------------------------------------------------------------
	logic [1:0]        phase_q;
	logic [LEFT_W-1:0] expected_q;
	logic [LEFT_W-1:0] seen_q;
	logic [UNIT_W-1:0] partial_q;

	// Emit one code point in the current output mode. UTF-16 splits a
	// supplementary point into a high and a low surrogate.
	function automatic emit_t emit_point(input logic [UNIT_W-1:0] c,
		input logic [MODE_W-1:0] mode);
		emit_t        r;
		logic [20:0]  v;
		v     = c[20:0] - CP_SUPP_BASE[20:0];
		r.cnt = 2'd1;
		r.u0  = c;
		r.e0  = 1'b0;
		r.u1  = '0;
		unique case (mode)
			MODE_UCS2: begin
				if (c >= CP_SUPP_BASE) begin
					r.u0 = CP_REPL;
					r.e0 = 1'b1;
				end
			end
			MODE_UCS4: begin
			end
			MODE_UTF16: begin
				if (c >= CP_LIMIT) begin
					r.u0 = CP_REPL;
					r.e0 = 1'b1;
				end else if (c >= CP_SUPP_BASE) begin
					r.cnt = 2'd2;
					r.u0  = {15'd0, HI_SUR_BASE + {6'd0, v[19:10]}};
					r.u1  = {15'd0, LO_SUR_BASE + {6'd0, v[9:0] & SUR_MASK}};
				end
			end
			MODE_UTF32: begin
				if (c >= CP_LIMIT) begin
					r.u0 = CP_REPL;
					r.e0 = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// Reject overlong forms, surrogates and the two noncharacters at the
	// top of the basic plane, otherwise emit the point.
	function automatic emit_t finish_point(input logic [LEFT_W-1:0] size,
		input logic [UNIT_W-1:0] c, input logic [MODE_W-1:0] mode);
		emit_t r;
		if ((c < min_for_size(size)) ||
			(c >= CP_SUR_LO && c <= CP_SUR_HI) ||
			(c >= CP_NONCH_LO && c <= CP_NONCH_HI)) begin
			r.cnt = 2'd1;
			r.u0  = CP_REPL;
			r.e0  = 1'b0;
			r.u1  = '0;
		end else begin
			r = emit_point(c, mode);
		end
		return r;
	endfunction

	// Treat a byte as the start of a new character. Fields of the state
	// that this byte does not touch keep their current values.
	function automatic dec_t start_byte(input logic [BYTE_W-1:0] b,
		input logic [LEFT_W-1:0] left, input dec_t cur, input logic [MODE_W-1:0] mode);
		dec_t              d;
		logic [LEFT_W-1:0] size;
		logic [BYTE_W-1:0] lead_mask;
		d          = cur;
		d.phase    = PH_IDLE;
		d.em.cnt   = 2'd1;
		d.em.u0    = CP_REPL;
		d.em.e0    = 1'b0;
		d.em.u1    = '0;
		priority casez (b)
			8'b110?????: size = 3'd2;
			8'b1110????: size = 3'd3;
			8'b11110???: size = 3'd4;
			8'b111110??: size = 3'd5;
			default:     size = 3'd6;
		endcase
		lead_mask = 8'h7f >> size;
		if (!b[7]) begin
			d.em = finish_point(3'd1, {23'd0, b}, mode);
		end else if (!b[6]) begin
			// Stray continuation byte: one replacement, then skip the run.
			if (left > 3'd1) begin
				d.phase    = PH_STRAY;
				d.expected = left - 3'd1;
			end
		end else if (b[7:1] == 7'b1111111) begin
			// Bytes FE and FF are never valid; only the byte itself is consumed.
		end else if (size > left) begin
			// The sequence runs past the end of the string: drop the rest.
			if (left > 3'd1) begin
				d.phase    = PH_SWALLOW;
				d.expected = left - 3'd1;
			end
		end else begin
			d.em.cnt    = 2'd0;
			d.phase     = PH_COLLECT;
			d.expected  = size;
			d.seen      = 3'd1;
			d.partial   = {23'd0, b & lead_mask};
		end
		return d;
	endfunction

	dec_t              cur_d;
	dec_t              nxt_d;
	dec_t              st_d;
	logic [LEFT_W-1:0] left_eff;
	logic [UNIT_W-1:0] cont_val;
	logic [LEFT_W-1:0] seen_inc;
	logic              is_cont;

	always_comb begin
		cur_d.em       = '0;
		cur_d.phase    = phase_q;
		cur_d.expected = expected_q;
		cur_d.seen     = seen_q;
		cur_d.partial  = partial_q;

		left_eff = (left_s1 == '0) ? 3'd1 : left_s1;
		is_cont  = (byte_s1[7:6] == 2'b10);
		cont_val = {partial_q[UNIT_W-7:0], byte_s1[5:0]};
		seen_inc = seen_q + 3'd1;
		st_d     = start_byte(byte_s1, left_eff, cur_d, mode_q);
		nxt_d    = cur_d;

		unique case (phase_q)
			PH_COLLECT: begin
				if (is_cont) begin
					nxt_d.partial = cont_val;
					nxt_d.seen    = seen_inc;
					if (seen_inc >= expected_q) begin
						nxt_d.phase = PH_IDLE;
						nxt_d.em    = finish_point(expected_q, cont_val, mode_q);
					end
				end else begin
					// Cut sequence: replace it, then decode this byte afresh.
					// A fresh start yields at most one unit here.
					nxt_d        = st_d;
					nxt_d.em.cnt = st_d.em.cnt + 2'd1;
					nxt_d.em.u0  = CP_REPL;
					nxt_d.em.e0  = 1'b0;
					nxt_d.em.u1  = st_d.em.u0;
				end
			end
			PH_STRAY: begin
				if (expected_q != '0 && is_cont) begin
					nxt_d.expected = expected_q - 3'd1;
					if (expected_q == 3'd1) begin
						nxt_d.phase = PH_IDLE;
					end
				end else begin
					nxt_d = st_d;
				end
			end
			PH_SWALLOW: begin
				if (expected_q != '0) begin
					nxt_d.expected = expected_q - 3'd1;
					if (expected_q == 3'd1) begin
						nxt_d.phase = PH_IDLE;
					end
				end else begin
					nxt_d = st_d;
				end
			end
			PH_IDLE: begin
				nxt_d = st_d;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			expected_q <= '0;
			seen_q     <= '0;
			partial_q  <= '0;
		end else if (fire_s1) begin
			phase_q    <= nxt_d.phase;
			expected_q <= nxt_d.expected;
			seen_q     <= nxt_d.seen;
			partial_q  <= nxt_d.partial;
		end
	end

	// ------------------------------------------------------------------
	// Result queue. A decoded byte writes zero, one or two entries; the output
	// channel drains one entry per cycle while the sink is ready. The stage-1 byte
	// is only decoded when two free entries are guaranteed for this cycle.
	// ------------------------------------------------------------------
	result_t               rq_mem [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]   wr_ptr_q;
	logic [RQ_PTR_W-1:0]   rd_ptr_q;
	logic [RQ_CNT_W-1:0]   cnt_q;
	logic [RQ_CNT_W-1:0]   cnt_after_pop;
	logic [RQ_CNT_W-1:0]   push_n;
	logic                  pop;
	logic [RQ_PTR_W-1:0]   wr_ptr_p1;

	assign pop           = out_stream.valid && out_stream.ready;
	assign cnt_after_pop = cnt_q - {{(RQ_CNT_W-1){1'b0}}, pop};
	assign fire_s1       = valid_s1 && (cnt_after_pop <= RQ_CNT_W'(RQ_DEPTH - 2));
	assign push_n        = fire_s1 ? {{(RQ_CNT_W-2){1'b0}}, nxt_d.em.cnt} : '0;
	assign wr_ptr_p1     = wr_ptr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[RQ_PTR_W-1:0];
			rd_ptr_q <= rd_ptr_q + {{(RQ_PTR_W-1){1'b0}}, pop};
			cnt_q    <= cnt_after_pop + push_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && nxt_d.em.cnt != 2'd0) begin
			rq_mem[wr_ptr_q] <= '{unit: nxt_d.em.u0, err: nxt_d.em.e0,
				last: (nxt_d.em.cnt == 2'd1)};
		end
		if (fire_s1 && nxt_d.em.cnt == 2'd2) begin
			rq_mem[wr_ptr_p1] <= '{unit: nxt_d.em.u1, err: 1'b0, last: 1'b1};
		end
	end

	assign out_stream.valid       = (cnt_q != '0);
	assign out_stream.code_unit   = rq_mem[rd_ptr_q].unit;
	assign out_stream.range_error = rq_mem[rd_ptr_q].err;
	assign out_stream.last_of_run = rq_mem[rd_ptr_q].last;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
`ifndef ASSERT_OFF
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RQ_CNT_W'(RQ_DEPTH))
		else $error("result queue holds more entries than it has");

	a_collect_short: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COLLECT |-> (seen_q < expected_q && expected_q >= 3'd2))
		else $error("collecting phase with a complete or impossible sequence");

	a_skip_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STRAY || phase_q == PH_SWALLOW) |-> expected_q != '0)
		else $error("skip phase with nothing left to skip");

	a_err_repl: assert property (@(posedge clk) disable iff (!arst_n)
		out_stream.valid && out_stream.range_error |-> out_stream.code_unit == CP_REPL)
		else $error("range error flagged on a unit other than the replacement");

	a_pair_push: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && nxt_d.em.cnt == 2'd2 && !pop |=> cnt_q == $past(cnt_q) + 3'd2)
		else $error("two-unit result did not add two queue entries");
`endif

endmodule

`default_nettype wire
